### rtl/hlmd_pkg.sv
// Shared types, character codes and decode helpers for the hex-length message deframer.
// No dependencies; compiled first.
package hlmd_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int LEN_OUT_W       = 32;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_VT   = 8'h0b;
	localparam logic [7:0] CH_FF   = 8'h0c;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] CH_UX   = 8'h58;

	typedef enum logic [1:0] {
		KIND_LABEL = 2'd0,
		KIND_BODY  = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [6:0] {
		PH_HEADER     = 7'b0000001,
		PH_LABEL_LEN  = 7'b0000010,
		PH_LABEL_DATA = 7'b0000100,
		PH_LABEL_SEP  = 7'b0001000,
		PH_BODY_LEN   = 7'b0010000,
		PH_BODY_DATA  = 7'b0100000,
		PH_BODY_SEP   = 7'b1000000
	} phase_t;

	// Position within a length line
	typedef enum logic [3:0] {
		PFX_SKIP   = 4'b0001,
		PFX_ZERO   = 4'b0010,
		PFX_DIGITS = 4'b0100,
		PFX_REST   = 4'b1000
	} pfx_t;

	typedef struct packed {
		logic   line_end;
		pfx_t   pfx_next;
		logic   sat;
	} len_ctl_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       new_connection;
	} in_item_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           out_byte;
		logic                 part_last;
		logic [LEN_OUT_W-1:0] label_length;
		logic [LEN_OUT_W-1:0] body_length;
		logic                 length_overflow;
	} out_item_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

### rtl/hlmd_stream_if.sv
// Valid/ready stream channel carrying one payload struct per request.
// Payload type is a parameter; uses no package directly.
interface hlmd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/hlmd_len_parser.sv
// One-byte step of a hex length line: blank skip, optional 0x, digits, saturation.
// Depends on hlmd_pkg.
module hlmd_len_parser import hlmd_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic [7:0]             c,
	input  pfx_t                   pfx,
	input  logic [LENGTH_BITS-1:0] acc,
	output len_ctl_t               ctl,
	output logic [LENGTH_BITS-1:0] acc_next
);

	logic [4:0]             hd;
	logic [LENGTH_BITS-1:0] base;
	logic [LENGTH_BITS-1:0] shifted;
	logic                   over;

	assign hd      = hex_digit(c);
	// first digit of a line starts from zero
	assign base    = (pfx == PFX_SKIP) ? '0 : acc;
	assign over    = |base[LENGTH_BITS-1 -: 4];
	assign shifted = over ? '1 : {base[LENGTH_BITS-5:0], hd[3:0]};

	always_comb begin
		ctl.line_end = (c == CH_LF);
		ctl.pfx_next = pfx;
		ctl.sat      = 1'b0;
		acc_next     = acc;
		if (!ctl.line_end) begin
			unique case (pfx)
				PFX_SKIP: begin
					if (is_blank(c)) begin
						ctl.pfx_next = PFX_SKIP;
					end else if (c == CH_ZERO) begin
						acc_next     = '0;
						ctl.pfx_next = PFX_ZERO;
					end else if (hd[4]) begin
						acc_next     = shifted;
						ctl.sat      = over;
						ctl.pfx_next = PFX_DIGITS;
					end else begin
						ctl.pfx_next = PFX_REST;
					end
				end
				PFX_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						ctl.pfx_next = PFX_DIGITS;
					end else if (hd[4]) begin
						acc_next     = shifted;
						ctl.sat      = over;
						ctl.pfx_next = PFX_DIGITS;
					end else begin
						ctl.pfx_next = PFX_REST;
					end
				end
				PFX_DIGITS: begin
					if (hd[4]) begin
						acc_next = shifted;
						ctl.sat  = over;
					end else begin
						ctl.pfx_next = PFX_REST;
					end
				end
				default: begin
					ctl.pfx_next = pfx;
				end
			endcase
		end
	end

endmodule

### rtl/hex_length_message_deframer.sv
// A byte is held in the input register; its result, if any, goes to the result
// register. Throughput: one byte per cycle; the input register advances whenever
// the result is empty or draining, so a stalled result holds one byte at most.
// Reset: arst_n clears the pipeline valids and puts the parser in header search;
// new_connection on a byte does the same for parse state before that byte.
module hex_length_message_deframer import hlmd_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hlmd_stream_if.sink          rx,
	hlmd_stream_if.source        tx
);

	// input register
	logic                   valid_s1;
	in_item_t               item_s1;

	// parse state
	phase_t                 phase_q;
	logic [1:0]             hdr_cnt_q;
	pfx_t                   pfx_q;
	logic [LENGTH_BITS-1:0] acc_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [LENGTH_BITS-1:0] saved_q;
	logic                   ovf_q;

	// result register
	logic                   out_valid_q;
	out_item_t              out_q;

	// state seen by the current byte (reset view on a new connection)
	phase_t                 phase_c;
	logic [1:0]             hdr_cnt_c;
	pfx_t                   pfx_c;
	logic [LENGTH_BITS-1:0] acc_c;
	logic [LENGTH_BITS-1:0] rem_c;
	logic [LENGTH_BITS-1:0] saved_c;
	logic                   ovf_c;

	phase_t                 phase_d;
	logic [1:0]             hdr_cnt_d;
	pfx_t                   pfx_d;
	logic [LENGTH_BITS-1:0] acc_d;
	logic [LENGTH_BITS-1:0] rem_d;
	logic [LENGTH_BITS-1:0] saved_d;
	logic                   ovf_d;

	logic                   emit;
	out_item_t              res;
	logic                   out_free;
	logic                   advance;
	logic [7:0]             c;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic [7:0]             hdr_char;
	len_ctl_t               lctl;
	logic [LENGTH_BITS-1:0] lacc;

	assign out_free = !out_valid_q || tx.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;
	assign tx.valid = out_valid_q;
	assign tx.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1 <= rx.data;
		end
	end

	assign c = item_s1.rx_byte;

	always_comb begin
		if (item_s1.new_connection) begin
			phase_c   = PH_HEADER;
			hdr_cnt_c = 2'd0;
			pfx_c     = PFX_SKIP;
			acc_c     = '0;
			rem_c     = '0;
			saved_c   = '0;
			ovf_c     = 1'b0;
		end else begin
			phase_c   = phase_q;
			hdr_cnt_c = hdr_cnt_q;
			pfx_c     = pfx_q;
			acc_c     = acc_q;
			rem_c     = rem_q;
			saved_c   = saved_q;
			ovf_c     = ovf_q;
		end
	end

	hlmd_len_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_len (
		.c        (c),
		.pfx      (pfx_c),
		.acc      (acc_c),
		.ctl      (lctl),
		.acc_next (lacc)
	);

	assign rem_dec  = rem_c - LENGTH_BITS'(1);
	// CR LF CR LF: even positions are CR
	assign hdr_char = hdr_cnt_c[0] ? CH_LF : CH_CR;

	always_comb begin
		phase_d   = phase_c;
		hdr_cnt_d = hdr_cnt_c;
		pfx_d     = pfx_c;
		acc_d     = acc_c;
		rem_d     = rem_c;
		saved_d   = saved_c;
		ovf_d     = ovf_c;
		emit      = 1'b0;
		res       = '0;
		unique case (phase_c) inside
			PH_LABEL_LEN, PH_BODY_LEN: begin
				if (lctl.line_end) begin
					rem_d = acc_c;
					if (phase_c == PH_LABEL_LEN) begin
						saved_d = acc_c;
						phase_d = (acc_c != '0) ? PH_LABEL_DATA : PH_LABEL_SEP;
					end else begin
						phase_d = (acc_c != '0) ? PH_BODY_DATA : PH_BODY_SEP;
					end
				end else begin
					pfx_d = lctl.pfx_next;
					acc_d = lacc;
					ovf_d = ovf_c | lctl.sat;
				end
			end
			PH_LABEL_DATA, PH_BODY_DATA: begin
				emit          = 1'b1;
				rem_d         = rem_dec;
				res.kind      = (phase_c == PH_LABEL_DATA) ? KIND_LABEL : KIND_BODY;
				res.out_byte  = c;
				res.part_last = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = (phase_c == PH_LABEL_DATA) ? PH_LABEL_SEP : PH_BODY_SEP;
				end
			end
			PH_LABEL_SEP: begin
				phase_d = PH_BODY_LEN;
				pfx_d   = PFX_SKIP;
				acc_d   = '0;
			end
			PH_BODY_SEP: begin
				emit                = 1'b1;
				res.kind            = KIND_DONE;
				res.label_length    = LEN_OUT_W'(saved_c);
				res.body_length     = LEN_OUT_W'(acc_c);
				res.length_overflow = ovf_c;
				ovf_d               = 1'b0;
				phase_d             = PH_LABEL_LEN;
				pfx_d               = PFX_SKIP;
				acc_d               = '0;
			end
			default: begin
				phase_d = PH_HEADER;
				if (c == hdr_char) begin
					if (hdr_cnt_c == 2'd3) begin
						hdr_cnt_d = 2'd0;
						phase_d   = PH_LABEL_LEN;
						pfx_d     = PFX_SKIP;
						acc_d     = '0;
					end else begin
						hdr_cnt_d = hdr_cnt_c + 2'd1;
					end
				end else begin
					// a stray CR may start a fresh match
					hdr_cnt_d = (c == CH_CR) ? 2'd1 : 2'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 2'd0;
			pfx_q     <= PFX_SKIP;
			acc_q     <= '0;
			rem_q     <= '0;
			saved_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			pfx_q     <= pfx_d;
			acc_q     <= acc_d;
			rem_q     <= rem_d;
			saved_q   <= saved_d;
			ovf_q     <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_data_phase_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LABEL_DATA || phase_q == PH_BODY_DATA) |-> (rem_q != '0))
		else $error("data phase entered with no bytes remaining");

	a_last_to_sep: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res.part_last)
		|=> (phase_q == PH_LABEL_SEP || phase_q == PH_BODY_SEP))
		else $error("final part byte did not lead to a separator");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && out_valid_q && !tx.ready))
		else $error("input stalled without a blocked result");

	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res.kind == KIND_DONE)
		|=> (phase_q == PH_LABEL_LEN && !ovf_q && acc_q == '0))
		else $error("completion did not restart the label length line");
`endif

endmodule
